// ===== sv/mccpm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the built-in parameter table of the controller mapper.
// No dependencies; every other file but mccpm_chk imports this package.
package mccpm_pkg;

    localparam int IDX_W       = 5;
    localparam int CC_W        = 8;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int TABLE_ROWS  = 27;

    localparam logic [CC_W-1:0] MIDI_TOP = 8'd127;
    localparam logic [CC_W-1:0] NO_CTL   = 8'd255;

    localparam logic signed [31:0] WAVE_SINE   = 32'sd0;
    localparam logic signed [31:0] WAVE_SAW    = 32'sd2;
    localparam logic signed [31:0] WAVE_SQUARE = 32'sd3;

    typedef enum logic [1:0] {
        KIND_CC   = 2'd0,
        KIND_SET  = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_LOAD,
        S_DIV,
        S_APPLY,
        S_FINISH,
        S_FETCH,
        S_SET,
        S_SHOW,
        S_ZERO
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_MUL,
        OP_DIV,
        OP_APPLY,
        OP_SET,
        OP_SHOW,
        OP_ZERO,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic step;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  idx_ok;
        logic  cc_ok;
        logic  match;
        logic  seen_same;
        logic  div_done;
        logic  scan_end;
    } t_stat;

    typedef struct packed {
        logic signed [31:0] def;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [CC_W-1:0]    ctl;
    } t_row;

    function automatic t_row table_row(input int unsigned i);
        t_row r;
        r = '{def: 32'sd0, lo: 32'sd0, hi: 32'sd0, ctl: NO_CTL};
        case (i)
            0:  r = '{32'sd0,   32'sd0,  32'sd1,    8'd255};
            1:  r = '{32'sd0,   32'sd0,  32'sd15,   8'd121};
            2:  r = '{32'sd120, 32'sd1,  32'sd600,  8'd255};
            3:  r = '{32'sd50,  32'sd10, 32'sd200,  8'd20};
            4:  r = '{32'sd0,   32'sd0,  32'sd360,  8'd21};
            5:  r = '{WAVE_SINE, 32'sd0, WAVE_SQUARE, 8'd22};
            6:  r = '{32'sd100, 32'sd0,  32'sd1000, 8'd23};
            7:  r = '{32'sd0,   32'sd0,  32'sd255,  8'd24};
            8:  r = '{32'sd255, 32'sd0,  32'sd255,  8'd25};
            9:  r = '{32'sd50,  32'sd10, 32'sd200,  8'd26};
            10: r = '{32'sd0,   32'sd0,  32'sd360,  8'd27};
            11: r = '{WAVE_SAW, 32'sd0,  WAVE_SQUARE, 8'd28};
            12: r = '{32'sd200, 32'sd0,  32'sd1000, 8'd29};
            13: r = '{32'sd0,   32'sd0,  32'sd255,  8'd30};
            14: r = '{32'sd255, 32'sd0,  32'sd255,  8'd31};
            15: r = '{32'sd50,  32'sd10, 32'sd200,  8'd102};
            16: r = '{32'sd0,   32'sd0,  32'sd360,  8'd103};
            17: r = '{WAVE_SQUARE, 32'sd0, WAVE_SQUARE, 8'd104};
            18: r = '{32'sd200, 32'sd0,  32'sd1000, 8'd105};
            19: r = '{32'sd0,   32'sd0,  32'sd255,  8'd106};
            20: r = '{32'sd255, 32'sd0,  32'sd255,  8'd107};
            21: r = '{32'sd50,  32'sd10, 32'sd200,  8'd108};
            22: r = '{32'sd0,   32'sd0,  32'sd360,  8'd109};
            23: r = '{WAVE_SAW, 32'sd0,  WAVE_SQUARE, 8'd110};
            24: r = '{32'sd200, 32'sd0,  32'sd1000, 8'd111};
            25: r = '{32'sd0,   32'sd0,  32'sd255,  8'd112};
            26: r = '{32'sd255, 32'sd0,  32'sd255,  8'd113};
            default: r = '{def: 32'sd0, lo: 32'sd0, hi: 32'sd0, ctl: NO_CTL};
        endcase
        return r;
    endfunction

endpackage

// ===== sv/mccpm_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the controller mapper.
// Depends on mccpm_pkg; drives the datapath through command beats only.
module mccpm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  mccpm_pkg::t_stat i_stat,
    output mccpm_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import mccpm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.kind)
                    KIND_CC:   n_state = i_stat.cc_ok ? S_SCAN : S_ZERO;
                    KIND_SET:  n_state = i_stat.idx_ok ? S_FETCH : S_ZERO;
                    KIND_READ: n_state = i_stat.idx_ok ? S_FETCH : S_ZERO;
                    default:   n_state = S_ZERO;
                endcase
            end
            S_FETCH:  n_state = (i_stat.kind == KIND_SET) ? S_SET : S_SHOW;
            S_SCAN: begin
                if (i_stat.match) begin
                    n_state = S_LOAD;
                end else if (i_stat.scan_end) begin
                    n_state = S_FINISH;
                end
            end
            S_LOAD: begin
                if (!i_stat.seen_same) begin
                    n_state = S_DIV;
                end else begin
                    n_state = i_stat.scan_end ? S_FINISH : S_SCAN;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY:  n_state = i_stat.scan_end ? S_FINISH : S_SCAN;
            S_SET:    n_state = S_IDLE;
            S_SHOW:   n_state = S_IDLE;
            S_ZERO:   n_state = S_IDLE;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '{op: OP_NONE, step: 1'b0};
        case (r_state)
            S_IDLE:   o_cmd.op = i_start ? OP_LOAD : OP_NONE;
            S_FETCH:  o_cmd.op = OP_READ;
            S_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.op = OP_READ;
                end else begin
                    o_cmd.step = !i_stat.scan_end;
                end
            end
            S_LOAD: begin
                if (i_stat.seen_same) begin
                    o_cmd.step = !i_stat.scan_end;
                end else begin
                    o_cmd.op = OP_MUL;
                end
            end
            S_DIV:    o_cmd.op = i_stat.div_done ? OP_NONE : OP_DIV;
            S_APPLY: begin
                o_cmd.op   = OP_APPLY;
                o_cmd.step = !i_stat.scan_end;
            end
            S_SET:    o_cmd.op = OP_SET;
            S_SHOW:   o_cmd.op = OP_SHOW;
            S_ZERO:   o_cmd.op = OP_ZERO;
            S_FINISH: o_cmd.op = OP_FINISH;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== sv/mccpm_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the controller mapper: entry memory, mapping arithmetic and result registers.
// Depends on mccpm_pkg; obeys command beats from mccpm_ctrl.
module mccpm_dpath #(
    parameter int NUM_ENTRIES = 32,
    parameter int VALUE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mccpm_pkg::t_cmd               i_cmd,
    output mccpm_pkg::t_stat              o_stat,
    input  logic [1:0]                    i_kind,
    input  logic [mccpm_pkg::CC_W-1:0]    i_cc_number,
    input  logic [mccpm_pkg::CC_W-1:0]    i_cc_value,
    input  logic [mccpm_pkg::IDX_W-1:0]   i_param_index,
    input  logic signed [VALUE_BITS-1:0]  i_set_value,
    output logic                          o_result_strobe,
    output logic [mccpm_pkg::IDX_W-1:0]   o_entry_index,
    output logic signed [VALUE_BITS-1:0]  o_old_value,
    output logic signed [VALUE_BITS-1:0]  o_new_value,
    output logic                          o_changed,
    output logic                          o_last
);
    import mccpm_pkg::*;

    // Internal values are wide enough for the built-in bounds at any port width.
    localparam int IB = (VALUE_BITS > 12) ? VALUE_BITS : 12;
    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int PW = IB + 8;
    localparam int RW = IB + 2;
    localparam int MW = IB + CC_W;

    logic [MW-1:0] mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_valid;
    logic [MW-1:0]          r_rd_row;
    logic                   r_rd_valid;

    t_kind                 r_kind;
    logic [CC_W-1:0]       r_ccn;
    logic [CC_W-1:0]       r_ccv;
    logic [IDX_W-1:0]      r_pidx;
    logic signed [VALUE_BITS-1:0] r_set;
    logic [IW-1:0]         r_addr;
    logic [PW-1:0]         r_y;
    logic [IB:0]           r_q;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_pend_valid;
    logic [IDX_W-1:0]      r_pend_idx;
    logic [IB-1:0]         r_pend_old;
    logic [IB-1:0]         r_pend_new;

    logic                  r_o_strobe, n_o_strobe;
    logic [IDX_W-1:0]      r_o_idx, n_o_idx;
    logic [VALUE_BITS-1:0] r_o_old, n_o_old;
    logic [VALUE_BITS-1:0] r_o_new, n_o_new;
    logic                  r_o_chg, n_o_chg;
    logic                  r_o_last, n_o_last;

    t_row                  w_row;
    logic signed [IB-1:0]  w_lo;
    logic signed [IB-1:0]  w_hi;
    logic signed [IB-1:0]  w_cur;
    logic [CC_W-1:0]       w_seen;
    logic signed [IB:0]    w_span;
    logic [PW-1:0]         w_prod;
    logic [PW-1:0]         w_y_hi;
    logic [PW-1:0]         w_y_next;
    logic [IB:0]           w_qf;
    logic signed [RW-1:0]  w_map;
    logic signed [RW-1:0]  w_req;
    logic signed [RW-1:0]  w_clip_hi;
    logic signed [RW-1:0]  w_clip;
    logic                  w_notify;
    logic signed [IB-1:0]  w_new;
    logic                  w_we;
    logic [MW-1:0]         w_wdata;
    logic                  w_report;
    logic [IDX_W-1:0]      w_addr_idx;

    assign w_row  = table_row(32'(r_addr));
    assign w_lo   = w_row.lo[IB-1:0];
    assign w_hi   = w_row.hi[IB-1:0];
    assign w_cur  = r_rd_valid ? r_rd_row[IB-1:0] : w_row.def[IB-1:0];
    assign w_seen = r_rd_valid ? r_rd_row[MW-1:IB] : NO_CTL;
    assign w_addr_idx = IDX_W'({{IDX_W{1'b0}}, r_addr});

    assign w_span   = (IB+1)'(w_hi) - (IB+1)'(w_lo);
    assign w_prod   = PW'(r_ccv[6:0]) * PW'($unsigned(w_span));
    assign w_y_hi   = r_y >> 7;
    assign w_y_next = w_y_hi + PW'(r_y[6:0]);
    assign w_qf     = r_q + ((r_y == PW'(MIDI_TOP)) ? (IB+1)'(1) : (IB+1)'(0));
    assign w_map    = $signed(RW'(w_qf)) + RW'(w_lo);

    assign w_req     = (i_cmd.op == OP_SET) ? RW'(r_set) : w_map;
    assign w_notify  = (w_req != RW'(w_cur));
    assign w_clip_hi = (w_req > RW'(w_hi)) ? RW'(w_hi) : w_req;
    assign w_clip    = (w_clip_hi < RW'(w_lo)) ? RW'(w_lo) : w_clip_hi;
    assign w_new     = w_notify ? w_clip[IB-1:0] : w_cur;

    assign w_we     = (i_cmd.op == OP_APPLY) || (i_cmd.op == OP_SET);
    assign w_wdata  = (i_cmd.op == OP_APPLY) ? {r_ccv, w_new} : {w_seen, w_new};
    assign w_report = (i_cmd.op == OP_APPLY) && w_notify && (r_cnt < CNT_W'(MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_addr] <= w_wdata;
        end
        if (i_cmd.op == OP_READ) begin
            r_rd_row   <= mem[r_addr];
            r_rd_valid <= r_valid[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_kind <= t_kind'(i_kind);
            r_ccn  <= i_cc_number;
            r_ccv  <= i_cc_value;
            r_pidx <= i_param_index;
            r_set  <= i_set_value;
            r_addr <= (t_kind'(i_kind) == KIND_CC) ? '0 : IW'(i_param_index);
        end else if (i_cmd.step) begin
            r_addr <= r_addr + IW'(1);
        end
        if (i_cmd.op == OP_MUL) begin
            r_y <= w_prod;
            r_q <= '0;
        end else if (i_cmd.op == OP_DIV) begin
            r_y <= w_y_next;
            r_q <= r_q + (IB+1)'(w_y_hi);
        end
        if (w_report) begin
            r_pend_idx <= w_addr_idx;
            r_pend_old <= w_cur;
            r_pend_new <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.op == OP_LOAD) begin
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
        end else if (w_report) begin
            r_cnt        <= r_cnt + CNT_W'(1);
            r_pend_valid <= 1'b1;
        end
    end

    // A reported update is held back one step so the final one can carry the last flag.
    always_comb begin
        n_o_strobe = 1'b0;
        n_o_idx    = r_o_idx;
        n_o_old    = r_o_old;
        n_o_new    = r_o_new;
        n_o_chg    = r_o_chg;
        n_o_last   = r_o_last;
        case (i_cmd.op)
            OP_APPLY: begin
                if (w_report && r_pend_valid) begin
                    n_o_strobe = 1'b1;
                    n_o_idx    = r_pend_idx;
                    n_o_old    = VALUE_BITS'(r_pend_old);
                    n_o_new    = VALUE_BITS'(r_pend_new);
                    n_o_chg    = 1'b1;
                    n_o_last   = 1'b0;
                end
            end
            OP_SET: begin
                n_o_strobe = 1'b1;
                n_o_idx    = r_pidx;
                n_o_old    = VALUE_BITS'(w_cur);
                n_o_new    = VALUE_BITS'(w_new);
                n_o_chg    = w_notify;
                n_o_last   = 1'b1;
            end
            OP_SHOW: begin
                n_o_strobe = 1'b1;
                n_o_idx    = r_pidx;
                n_o_old    = VALUE_BITS'(w_cur);
                n_o_new    = VALUE_BITS'(w_cur);
                n_o_chg    = 1'b0;
                n_o_last   = 1'b1;
            end
            OP_ZERO: begin
                n_o_strobe = 1'b1;
                n_o_idx    = '0;
                n_o_old    = '0;
                n_o_new    = '0;
                n_o_chg    = 1'b0;
                n_o_last   = 1'b1;
            end
            OP_FINISH: begin
                n_o_strobe = 1'b1;
                n_o_idx    = r_pend_valid ? r_pend_idx : '0;
                n_o_old    = r_pend_valid ? VALUE_BITS'(r_pend_old) : '0;
                n_o_new    = r_pend_valid ? VALUE_BITS'(r_pend_new) : '0;
                n_o_chg    = r_pend_valid;
                n_o_last   = 1'b1;
            end
            default: begin
                n_o_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= n_o_strobe;
        end
        r_o_idx  <= n_o_idx;
        r_o_old  <= n_o_old;
        r_o_new  <= n_o_new;
        r_o_chg  <= n_o_chg;
        r_o_last <= n_o_last;
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.idx_ok    = ({{(32-IDX_W){1'b0}}, r_pidx} < 32'(NUM_ENTRIES));
    assign o_stat.cc_ok     = (r_ccn <= MIDI_TOP) && (r_ccv <= MIDI_TOP);
    assign o_stat.match     = (w_row.ctl == r_ccn);
    assign o_stat.seen_same = (w_seen == r_ccv);
    assign o_stat.div_done  = (w_y_hi == '0);
    assign o_stat.scan_end  = (r_addr == IW'(NUM_ENTRIES - 1));

    assign o_result_strobe = r_o_strobe;
    assign o_entry_index   = r_o_idx;
    assign o_old_value     = $signed(r_o_old);
    assign o_new_value     = $signed(r_o_new);
    assign o_changed       = r_o_chg;
    assign o_last          = r_o_last;

endmodule

// ===== sv/midi_cc_parameter_mapper_unit.sv =====
`timescale 1ns / 1ps
// Top level of the controller-to-parameter mapper: sequencer plus datapath.
// Depends on mccpm_pkg, mccpm_ctrl and mccpm_dpath.
//
//  channel   direction  handshake                 payload
//  command   in         start && !busy            i_kind, i_cc_number, i_cc_value,
//                                                 i_param_index, i_set_value
//  result    out        o_result_strobe, 1 cycle  o_entry_index, o_old_value,
//                                                 o_new_value, o_changed, o_last
//
// A control change walks every entry in turn; an entry whose controller matches
// gets a memory read, and one whose stored controller value differs is then multiplied,
// divided by 127 in 7-bit folds and written back. Direct set and read decode, fetch the
// entry and then set or show it; an ignored item decodes and returns a zero beat.
// Reset restores the built-in table at once through per-entry valid bits; no clearing pass.
// Results cannot be held off; each beat is on the ports for exactly one cycle.
module midi_cc_parameter_mapper_unit #(
    parameter int NUM_ENTRIES = 32,
    parameter int VALUE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_kind,
    input  logic [mccpm_pkg::CC_W-1:0]    i_cc_number,
    input  logic [mccpm_pkg::CC_W-1:0]    i_cc_value,
    input  logic [mccpm_pkg::IDX_W-1:0]   i_param_index,
    input  logic signed [VALUE_BITS-1:0]  i_set_value,
    output logic                          o_result_strobe,
    output logic [mccpm_pkg::IDX_W-1:0]   o_entry_index,
    output logic signed [VALUE_BITS-1:0]  o_old_value,
    output logic signed [VALUE_BITS-1:0]  o_new_value,
    output logic                          o_changed,
    output logic                          o_last
);
    import mccpm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    mccpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    mccpm_dpath #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_kind          (i_kind),
        .i_cc_number     (i_cc_number),
        .i_cc_value      (i_cc_value),
        .i_param_index   (i_param_index),
        .i_set_value     (i_set_value),
        .o_result_strobe (o_result_strobe),
        .o_entry_index   (o_entry_index),
        .o_old_value     (o_old_value),
        .o_new_value     (o_new_value),
        .o_changed       (o_changed),
        .o_last          (o_last)
    );

endmodule

// ===== sv/mccpm_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks of the controller mapper, attached to the top level by bind.
// Depends on midi_cc_parameter_mapper_unit.
module mccpm_chk #(
    parameter int VALUE_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_result_strobe,
    input logic signed [VALUE_BITS-1:0] o_old_value,
    input logic signed [VALUE_BITS-1:0] o_new_value,
    input logic                         o_changed,
    input logic                         o_last
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_result_strobe)
        else $error("busy or result beat right after reset");

    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy && !o_result_strobe)
        else $error("accepted command did not hold the block busy");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_last) |-> !busy)
        else $error("block still busy after final result beat");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_last) |-> busy)
        else $error("non-final result beat while idle");

    a_unchanged_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_changed) |-> (o_old_value == o_new_value))
        else $error("unchanged result reports differing values");

endmodule

bind midi_cc_parameter_mapper_unit mccpm_chk #(
    .VALUE_BITS (VALUE_BITS)
) u_mccpm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_old_value     (o_old_value),
    .o_new_value     (o_new_value),
    .o_changed       (o_changed),
    .o_last          (o_last)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for midi_cc_parameter_mapper_unit: control change, direct set and read.
// Depends on mccpm_pkg and the mapper RTL; it predicts every result beat from its own table copy.
module tb_top;

    import mccpm_pkg::*;

    localparam int NUM_ENTRIES = 32;
    localparam int VALUE_BITS  = 16;

    localparam int DEF_VALUE [TABLE_ROWS] = '{
        0, 0, 120, 50, 0, WAVE_SINE, 100, 0, 255, 50, 0, WAVE_SAW, 200, 0, 255,
        50, 0, WAVE_SQUARE, 200, 0, 255, 50, 0, WAVE_SAW, 200, 0, 255};
    localparam int DEF_LOW [TABLE_ROWS] = '{
        0, 0, 1, 10, 0, 0, 0, 0, 0, 10, 0, 0, 0, 0, 0,
        10, 0, 0, 0, 0, 0, 10, 0, 0, 0, 0, 0};
    localparam int DEF_HIGH [TABLE_ROWS] = '{
        1, 15, 600, 200, 360, WAVE_SQUARE, 1000, 255, 255, 200, 360, WAVE_SQUARE, 1000, 255,
        255, 200, 360, WAVE_SQUARE, 1000, 255, 255, 200, 360, WAVE_SQUARE, 1000, 255, 255};
    localparam int DEF_CTL [TABLE_ROWS] = '{
        255, 121, 255, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31,
        102, 103, 104, 105, 106, 107, 108, 109, 110, 111, 112, 113};

    typedef struct {
        t_kind                        kind;
        logic [CC_W-1:0]              ccn;
        logic [CC_W-1:0]              ccv;
        logic [IDX_W-1:0]             idx;
        logic signed [VALUE_BITS-1:0] setv;
    } t_midi_cmd;

    typedef struct {
        logic [IDX_W-1:0]      idx;
        logic [VALUE_BITS-1:0] old_v;
        logic [VALUE_BITS-1:0] new_v;
        logic                  changed;
        logic                  last;
    } t_param_update;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [1:0] i_kind;
    logic [CC_W-1:0] i_cc_number;
    logic [CC_W-1:0] i_cc_value;
    logic [IDX_W-1:0] i_param_index;
    logic signed [VALUE_BITS-1:0] i_set_value;
    logic o_result_strobe;
    logic [IDX_W-1:0] o_entry_index;
    logic signed [VALUE_BITS-1:0] o_old_value;
    logic signed [VALUE_BITS-1:0] o_new_value;
    logic o_changed;
    logic o_last;

    int param_value [NUM_ENTRIES];
    int param_low [NUM_ENTRIES];
    int param_high [NUM_ENTRIES];
    logic [CC_W-1:0] param_ctl [NUM_ENTRIES];
    logic [CC_W-1:0] param_last_cc [NUM_ENTRIES];

    t_param_update pending_updates[$];
    int error_count = 0;
    int items_sent = 0;
    int beats_seen = 0;
    int changed_beats = 0;
    bit allow_gaps = 1'b1;

    midi_cc_parameter_mapper_unit #(
        .NUM_ENTRIES(NUM_ENTRIES),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_cc_number(i_cc_number),
        .i_cc_value(i_cc_value),
        .i_param_index(i_param_index),
        .i_set_value(i_set_value),
        .o_result_strobe(o_result_strobe),
        .o_entry_index(o_entry_index),
        .o_old_value(o_old_value),
        .o_new_value(o_new_value),
        .o_changed(o_changed),
        .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic void load_default_table();
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (i < TABLE_ROWS) begin
                param_value[i] = DEF_VALUE[i];
                param_low[i]   = DEF_LOW[i];
                param_high[i]  = DEF_HIGH[i];
                param_ctl[i]   = 8'(DEF_CTL[i]);
            end else begin
                param_value[i] = 0;
                param_low[i]   = 0;
                param_high[i]  = 0;
                param_ctl[i]   = NO_CTL;
            end
            param_last_cc[i] = NO_CTL;
        end
    endfunction

    // A request equal to the current value is not notified; otherwise it is clamped and notified.
    function automatic bit apply_request(input int e, input int req, output int old_v,
                                         output int new_v);
        int v;
        old_v = param_value[e];
        new_v = param_value[e];
        if (req == param_value[e]) return 1'b0;
        v = req;
        if (v > param_high[e]) v = param_high[e];
        if (v < param_low[e]) v = param_low[e];
        param_value[e] = v;
        new_v = v;
        return 1'b1;
    endfunction

    function automatic void compute_param_updates(input t_midi_cmd c);
        int req;
        int old_v;
        int new_v;
        int span;
        int n;
        bit chg;
        n = 0;
        case (c.kind)
            KIND_CC: begin
                if (c.ccn <= MIDI_TOP && c.ccv <= MIDI_TOP) begin
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        if (param_ctl[i] != c.ccn || param_last_cc[i] == c.ccv) continue;
                        span = param_high[i] - param_low[i];
                        req = (int'(c.ccv) * span) / int'(MIDI_TOP) + param_low[i];
                        if (apply_request(i, req, old_v, new_v) && n < MAX_RESULTS) begin
                            pending_updates.push_back('{5'(i), 16'(old_v), 16'(new_v),
                                                        1'b1, 1'b0});
                            n++;
                        end
                        param_last_cc[i] = c.ccv;
                    end
                end
                if (n == 0) pending_updates.push_back('{'0, '0, '0, 1'b0, 1'b1});
                else pending_updates[pending_updates.size() - 1].last = 1'b1;
            end
            KIND_SET: begin
                chg = apply_request(int'(c.idx), int'(c.setv), old_v, new_v);
                pending_updates.push_back('{c.idx, 16'(old_v), 16'(new_v), chg, 1'b1});
            end
            KIND_READ: begin
                pending_updates.push_back('{c.idx, 16'(param_value[c.idx]),
                                            16'(param_value[c.idx]), 1'b0, 1'b1});
            end
            default: pending_updates.push_back('{'0, '0, '0, 1'b0, 1'b1});
        endcase
    endfunction

    function automatic t_midi_cmd cc_cmd(input int ccn, input int ccv);
        t_midi_cmd c;
        c = '{KIND_CC, 8'(ccn), 8'(ccv), 5'($urandom), 16'($urandom)};
        return c;
    endfunction

    function automatic t_midi_cmd set_cmd(input int idx, input int v);
        t_midi_cmd c;
        c = '{KIND_SET, 8'($urandom), 8'($urandom), 5'(idx), 16'(v)};
        return c;
    endfunction

    function automatic t_midi_cmd read_cmd(input int idx, input t_kind k);
        t_midi_cmd c;
        c = '{k, 8'($urandom), 8'($urandom), 5'(idx), 16'($urandom)};
        return c;
    endfunction

    // Half control changes, mostly on assigned controllers, with repeats and out-of-range bytes.
    function automatic t_midi_cmd random_cmd();
        int e;
        int n;
        int v;
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            e = $urandom_range(0, TABLE_ROWS - 1);
            case ($urandom_range(0, 9))
                0: n = $urandom_range(128, 255);
                1: n = $urandom_range(0, 127);
                default: n = param_ctl[e];
            endcase
            if ($urandom_range(0, 9) == 0) v = $urandom_range(128, 255);
            else if ($urandom_range(0, 3) == 0 && param_last_cc[e] <= MIDI_TOP)
                v = param_last_cc[e];
            else v = $urandom_range(0, 127);
            return cc_cmd(n, v);
        end
        if (r < 75) begin
            e = $urandom_range(0, NUM_ENTRIES - 1);
            case ($urandom_range(0, 5))
                0, 1, 2: v = $urandom_range(0, param_high[e] - param_low[e] + 6)
                             + param_low[e] - 3;
                3: v = param_value[e];
                default: v = int'($signed(16'($urandom)));
            endcase
            return set_cmd(e, v);
        end
        if (r < 93) return read_cmd($urandom_range(0, NUM_ENTRIES - 1), KIND_READ);
        return read_cmd($urandom_range(0, NUM_ENTRIES - 1), KIND_NONE);
    endfunction

    task automatic send_command(input t_midi_cmd c);
        start <= 1'b1;
        i_kind <= c.kind;
        i_cc_number <= c.ccn;
        i_cc_value <= c.ccv;
        i_param_index <= c.idx;
        i_set_value <= c.setv;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        compute_param_updates(c);
        items_sent++;
        if (allow_gaps && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_param_update want;
        if (i_rst_n === 1'b1 && o_result_strobe === 1'b1) begin
            beats_seen++;
            if (pending_updates.size() == 0) begin
                report_mismatch($sformatf("unexpected beat for entry %0d", o_entry_index));
            end else begin
                want = pending_updates.pop_front();
                if (o_changed === 1'b1) changed_beats++;
                if (o_entry_index !== want.idx)
                    report_mismatch($sformatf("entry_index got %0d want %0d",
                                              o_entry_index, want.idx));
                if (o_old_value !== want.old_v)
                    report_mismatch($sformatf("entry %0d old_value got %0d want %0d",
                                              want.idx, o_old_value, $signed(want.old_v)));
                if (o_new_value !== want.new_v)
                    report_mismatch($sformatf("entry %0d new_value got %0d want %0d",
                                              want.idx, o_new_value, $signed(want.new_v)));
                if (o_changed !== want.changed)
                    report_mismatch($sformatf("entry %0d changed got %b want %b",
                                              want.idx, o_changed, want.changed));
                if (o_last !== want.last)
                    report_mismatch($sformatf("entry %0d last got %b want %b",
                                              want.idx, o_last, want.last));
            end
        end
    end

    task automatic test_cc_mapping();
        send_command(cc_cmd(20, 0));
        send_command(cc_cmd(20, 127));
        send_command(cc_cmd(20, 127));
        send_command(cc_cmd(22, 64));
        send_command(cc_cmd(121, 127));
        send_command(cc_cmd(23, 10));
        send_command(cc_cmd(25, 127));
        send_command(cc_cmd(5, 10));
    endtask

    task automatic test_ignored_messages();
        send_command(cc_cmd(200, 5));
        send_command(cc_cmd(20, 200));
        send_command(cc_cmd(255, 128));
    endtask

    task automatic test_direct_set();
        send_command(set_cmd(3, 32767));
        send_command(set_cmd(3, -32768));
        send_command(set_cmd(3, 10));
        send_command(set_cmd(31, 5));
        send_command(set_cmd(2, 300));
        send_command(set_cmd(0, 1));
    endtask

    task automatic test_read_and_unused();
        send_command(read_cmd(2, KIND_READ));
        send_command(read_cmd(31, KIND_READ));
        send_command(read_cmd(0, KIND_READ));
        send_command(read_cmd(0, KIND_NONE));
        send_command(read_cmd(31, KIND_NONE));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_command(random_cmd());
    endtask

    task automatic test_back_to_back(input int count);
        allow_gaps = 1'b0;
        repeat (count) send_command(random_cmd());
    endtask

    initial begin : main_sequence
        int guard;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_kind <= KIND_CC;
        i_cc_number <= '0;
        i_cc_value <= '0;
        i_param_index <= '0;
        i_set_value <= '0;
        load_default_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cc_mapping();
        test_ignored_messages();
        test_direct_set();
        test_read_and_unused();
        test_random_traffic(300);
        test_back_to_back(50);

        start <= 1'b0;
        guard = 0;
        while (pending_updates.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
        if (pending_updates.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      pending_updates.size()));

        $display("Sent %0d commands (control change, direct set, read, unused kind).",
                 items_sent);
        $display("Checked %0d result beats, %0d of them value changes, %0d errors.",
                 beats_seen, changed_beats, error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Timeout: the run did not finish in time.");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
